@@ hw/rtl/bfgr_pkg.sv @@
// Shared types, constants and defaults of the bitmap font glyph renderer.
package bfgr_pkg;

	localparam int MAX_GLYPHS_DEF = 512;
	localparam int MAX_HEIGHT_DEF = 32;
	localparam int PIXEL_BYTES = 4;
	localparam int PIX_SHIFT = $clog2(PIXEL_BYTES);
	localparam int HEIGHT_CAP = 32;
	localparam int COLUMNS = 8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [15:0] char_code;
		logic [4:0]  glyph_row;
		logic [7:0]  row_bits;
		logic [7:0]  text_column;
		logic [7:0]  text_row;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
	} in_item_t;

	typedef struct packed {
		logic [31:0] row_address;
		logic [31:0] pixel_0;
		logic [31:0] pixel_1;
		logic [31:0] pixel_2;
		logic [31:0] pixel_3;
		logic [31:0] pixel_4;
		logic [31:0] pixel_5;
		logic [31:0] pixel_6;
		logic [31:0] pixel_7;
		logic [3:0]  valid_columns;
		logic        last_row;
	} result_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic mul1;
		logic mul2;
		logic base;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic h_zero;
		logic last;
	} ctrl_sts_t;

endpackage

@@ hw/rtl/bitmap_font_glyph_renderer.sv @@
// Top level of the bitmap font glyph renderer: controller and datapath.
//
// Channel   Direction  Handshake                  Payload
// item      in         start high, busy low       in_item_t (load row or draw character)
// result    out        result_strobe, one cycle   result_t (one glyph row per transaction)
// cfg       in         cfg_valid and cfg_ready    cfg_index, cfg_data
//
// A load transaction leaves busy low, so loads may follow every cycle outside a draw.
// A draw holds busy through two multiply stages, one address add, then one row per cycle
// read from the dual-port glyph store; each result appears in the cycle after its row.
// A draw with zero height holds busy for one cycle and gives no result. Reset is
// asynchronous, clears control state and the strobe and loads config defaults; the glyph
// store is not cleared. The receiver cannot stall results, and cfg_ready is always high.
module bitmap_font_glyph_renderer #(
	parameter int MAX_GLYPHS = bfgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_HEIGHT = bfgr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bfgr_pkg::in_item_t              item,
	output bfgr_pkg::result_t               result,
	output logic                            result_strobe,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	bfgr_pkg::ctrl_cmd_t cmd;
	bfgr_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	bfgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_cmd (item.cmd),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	bfgr_datapath #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

@@ hw/rtl/bfgr_ctrl.sv @@
// Controller state machine that sequences glyph loads and character draws.
module bfgr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 item_cmd,
	input  bfgr_pkg::ctrl_sts_t  sts,
	output logic                 busy,
	output bfgr_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_BASE,
		S_ROW
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	always_comb begin
		cmd = '0;
		cmd.load = accept && (item_cmd == bfgr_pkg::CMD_LOAD);
		cmd.capture = accept && (item_cmd == bfgr_pkg::CMD_DRAW);
		cmd.mul1 = (state_q == S_MUL1);
		cmd.mul2 = (state_q == S_MUL2);
		cmd.base = (state_q == S_BASE);
		cmd.emit = (state_q == S_ROW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item_cmd == bfgr_pkg::CMD_DRAW)) begin
						state_q <= S_MUL1;
						busy_q <= 1'b1;
					end
				end
				S_MUL1: begin
					if (sts.h_zero) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_BASE;
				end
				S_BASE: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (sts.last) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE))
		else $error("glyph load taken while a draw is in progress");

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy disagrees with controller state");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(state_q == S_ROW) || $past(state_q == S_MUL1)))
		else $error("draw ended outside the row or setup state");

	a_row_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> !sts.h_zero)
		else $error("rows emitted for a zero-height glyph");

endmodule

@@ hw/rtl/bfgr_datapath.sv @@
// Datapath with configuration registers, glyph store, address arithmetic and result register.
module bfgr_datapath #(
	parameter int MAX_GLYPHS = bfgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_HEIGHT = bfgr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bfgr_pkg::in_item_t              item,
	input  bfgr_pkg::ctrl_cmd_t             cmd,
	output bfgr_pkg::ctrl_sts_t             sts,
	input  logic                            cfg_valid,
	input  logic [bfgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	output bfgr_pkg::result_t               result,
	output logic                            result_strobe
);

	localparam int GW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW = GW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int H_LIM = (MAX_HEIGHT < bfgr_pkg::HEIGHT_CAP) ? MAX_HEIGHT
		: bfgr_pkg::HEIGHT_CAP;

	logic [31:0] frame_base_q;
	logic [15:0] pitch_q;
	logic [9:0]  glyph_count_q;
	logic [3:0]  glyph_width_q;
	logic [5:0]  glyph_height_q;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [5:0] load_row;
	logic [5:0] next_row;

	bfgr_pkg::in_item_t item_q;
	logic [5:0]    h_q;
	logic [3:0]    w_q;
	logic [GW-1:0] glyph_q;
	logic [5:0]    row_q;
	logic [31:0]   addr_q;
	logic [13:0]   cyh_s1;
	logic [11:0]   cxw_s1;
	logic [29:0]   prod_s2;
	logic [11:0]   cxw_s2;

	logic [5:0]    h_new;
	logic [3:0]    w_new;
	logic [GW-1:0] glyph_new;
	logic [31:0]   px [bfgr_pkg::COLUMNS];

	bfgr_pkg::result_t result_q;
	logic              strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= 32'd0;
			pitch_q <= 16'd5120;
			glyph_count_q <= 10'd256;
			glyph_width_q <= 4'd8;
			glyph_height_q <= 6'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bfgr_pkg::CFG_FRAME_BASE: frame_base_q <= cfg_data;
				bfgr_pkg::CFG_PITCH: pitch_q <= cfg_data[15:0];
				bfgr_pkg::CFG_GLYPH_COUNT: glyph_count_q <= cfg_data[9:0];
				bfgr_pkg::CFG_GLYPH_WIDTH: glyph_width_q <= cfg_data[3:0];
				bfgr_pkg::CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	assign load_row = 6'(item.glyph_row);
	assign wr_en = cmd.load && (32'(item.char_code) < MAX_GLYPHS)
		&& (32'(item.glyph_row) < MAX_HEIGHT);
	assign wr_addr = {item.char_code[GW-1:0], load_row[RW-1:0]};
	assign next_row = cmd.base ? 6'd0 : (row_q + 6'd1);
	assign rd_addr = {glyph_q, next_row[RW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item.row_bits;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		if (glyph_height_q > 6'(H_LIM)) begin
			h_new = 6'(H_LIM);
		end else begin
			h_new = glyph_height_q;
		end
		if (glyph_width_q == 4'd0) begin
			w_new = 4'd1;
		end else if (glyph_width_q > 4'd8) begin
			w_new = 4'd8;
		end else begin
			w_new = glyph_width_q;
		end
		if ((item.char_code == 16'd0) || (32'(item.char_code) >= 32'(glyph_count_q))
			|| (32'(item.char_code) >= MAX_GLYPHS)) begin
			glyph_new = '0;
		end else begin
			glyph_new = item.char_code[GW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			h_q <= h_new;
			w_q <= w_new;
			glyph_q <= glyph_new;
		end
		if (cmd.mul1) begin
			cyh_s1 <= 14'(item_q.text_row) * 14'(h_q);
			cxw_s1 <= 12'(item_q.text_column) * (12'(w_q) + 12'd1);
		end
		if (cmd.mul2) begin
			prod_s2 <= 30'(cyh_s1) * 30'(pitch_q);
			cxw_s2 <= cxw_s1;
		end
		if (cmd.base) begin
			addr_q <= frame_base_q + 32'(prod_s2)
				+ (32'(cxw_s2) << bfgr_pkg::PIX_SHIFT);
			row_q <= 6'd0;
		end else if (cmd.emit) begin
			addr_q <= addr_q + 32'(pitch_q);
			row_q <= row_q + 6'd1;
		end
	end

	assign sts.h_zero = (h_q == 6'd0);
	assign sts.last = ((row_q + 6'd1) == h_q);

	always_comb begin
		for (int i = 0; i < bfgr_pkg::COLUMNS; i++) begin
			if (4'(i) < w_q) begin
				px[i] = rd_data_q[bfgr_pkg::COLUMNS-1-i] ? item_q.fg_color
					: item_q.bg_color;
			end else begin
				px[i] = 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.row_address <= addr_q;
			result_q.pixel_0 <= px[0];
			result_q.pixel_1 <= px[1];
			result_q.pixel_2 <= px[2];
			result_q.pixel_3 <= px[3];
			result_q.pixel_4 <= px[4];
			result_q.pixel_5 <= px[5];
			result_q.pixel_6 <= px[6];
			result_q.pixel_7 <= px[7];
			result_q.valid_columns <= w_q;
			result_q.last_row <= sts.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	assign result = result_q;
	assign result_strobe = strobe_q;

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (row_q < h_q))
		else $error("row emitted past the glyph height");

	a_strobe_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(cmd.emit))
		else $error("result strobe without an emitted row");

	a_address_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && $past(cmd.emit)) |-> (addr_q == $past(addr_q) + 32'(pitch_q)))
		else $error("row address did not advance by one scanline");

endmodule
